[rtl/core/page_framebuffer_with_refresh_stream_defines.svh]
// Assertion macros for the page frame buffer.
// Define ASSERT_OFF to compile the checks out.
`ifndef PAGE_FRAMEBUFFER_WITH_REFRESH_STREAM_DEFINES_SVH
`define PAGE_FRAMEBUFFER_WITH_REFRESH_STREAM_DEFINES_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define PGFB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page frame buffer check failed");
// The consequent must hold in the cycle after the antecedent.
`define PGFB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page frame buffer check failed");
`else
`define PGFB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PGFB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/pgfb_pkg.sv]
package pgfb_pkg;

    localparam int DEF_COLUMNS = 128;
    localparam int DEF_PAGES   = 8;

    // Refresh stream layout: three command bytes open each page.
    localparam int HEADER_LEN   = 3;
    localparam int IDX_PAGE_CMD = 0;
    localparam int IDX_COL_LOW  = 1;
    localparam int IDX_COL_HIGH = 2;

    localparam logic [7:0] CMD_PAGE         = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH     = 8'h10;
    localparam logic [7:0] CFG_OFFSET_RESET = 8'h02;

    typedef enum logic [1:0] {
        ACT_POINT   = 2'd0,
        ACT_COLUMN  = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_REFRESH = 2'd3
    } t_action;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the operands of an accepted request
        logic rd;        // read the store for a read-modify-write
        logic wr;        // write the merged byte back
        logic hi;        // address the second page of a draw column
        logic clr_wr;    // write zero at the sweep address and advance it
        logic ref_rd;    // read the store at the refresh position
        logic ref_load;  // load the output register and advance the refresh position
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_hi;     // draw column spills into a visible second page
        logic sweep_last;  // sweep address is at the last entry
        logic out_free;    // output register can take a new result this cycle
    } t_dp_sts;

endpackage

[rtl/core/pgfb_ctrl.sv]
module pgfb_ctrl
    import pgfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    output logic       o_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_sts    i_sts
);

    typedef enum logic [7:0] {
        ST_CLR     = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_RD_LO   = 8'b0000_0100,
        ST_WR_LO   = 8'b0000_1000,
        ST_RD_HI   = 8'b0001_0000,
        ST_WR_HI   = 8'b0010_0000,
        ST_REF_RD  = 8'b0100_0000,
        ST_REF_OUT = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_action'(i_action))
                        ACT_POINT:   n_state = ST_RD_LO;
                        ACT_COLUMN:  n_state = ST_RD_LO;
                        ACT_CLEAR:   n_state = ST_CLR;
                        default:     n_state = ST_REF_RD;
                    endcase
                end
            end
            ST_RD_LO: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_WR_LO;
            end
            ST_WR_LO: begin
                o_cmd.wr = 1'b1;
                n_state  = i_sts.need_hi ? ST_RD_HI : ST_IDLE;
            end
            ST_RD_HI: begin
                o_cmd.rd = 1'b1;
                o_cmd.hi = 1'b1;
                n_state  = ST_WR_HI;
            end
            ST_WR_HI: begin
                o_cmd.wr = 1'b1;
                o_cmd.hi = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REF_RD: begin
                o_cmd.ref_rd = 1'b1;
                n_state      = ST_REF_OUT;
            end
            ST_REF_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.ref_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

[rtl/core/pgfb_dp.sv]
module pgfb_dp
    import pgfb_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic [1:0] i_action,
    input  logic [7:0] i_x_coord,
    input  logic [7:0] i_y_coord,
    input  logic [7:0] i_pattern,
    input  logic       i_pixel_value,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_last_of_frame
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int IW    = $clog2(COLUMNS + HEADER_LEN);

    // Operands of the current draw request.
    logic       r_op_col;
    logic [7:0] r_x;
    logic [5:0] r_page;
    logic [2:0] r_shift;
    logic [7:0] r_pat;
    logic       r_pv;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;
    logic [AW-1:0] r_clr_addr;

    logic [PW-1:0] r_ref_page;
    logic [IW-1:0] r_ref_idx;
    logic [7:0]    r_offset;

    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic       r_o_data;
    logic       r_o_last;

    logic [5:0]    w_page_next;
    logic [5:0]    w_page_sel;
    logic          w_x_ok;
    logic          w_page_ok;
    logic [15:0]   w_rmw_full;
    logic [15:0]   w_ref_full;
    logic [AW-1:0] w_rmw_addr;
    logic [AW-1:0] w_ref_addr;
    logic [3:0]    w_sh_hi;
    logic [7:0]    w_mask;
    logic [7:0]    w_bits;
    logic [7:0]    w_merged;
    logic          w_we;
    logic          w_re;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_wdata;
    logic          w_last_idx;
    logic          w_last_page;
    logic [7:0]    w_ref_byte;
    logic          w_ref_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op_col <= (t_action'(i_action) == ACT_COLUMN);
            r_x      <= i_x_coord;
            r_page   <= {1'b0, i_y_coord[7:3]};
            r_shift  <= i_y_coord[2:0];
            r_pat    <= i_pixel_value ? i_pattern : ~i_pattern;
            r_pv     <= i_pixel_value;
        end
    end

    assign w_page_next = r_page + 6'd1;
    assign w_page_sel  = i_cmd.hi ? w_page_next : r_page;
    assign w_x_ok      = ({1'b0, r_x} < 9'(COLUMNS));
    assign w_page_ok   = (w_page_sel < 6'(PAGES));
    assign w_rmw_full  = 16'(w_page_sel) * 16'(COLUMNS) + 16'(r_x);
    assign w_rmw_addr  = w_rmw_full[AW-1:0];
    assign w_ref_full  = 16'(r_ref_page) * 16'(COLUMNS) + 16'(r_ref_idx) - 16'(HEADER_LEN);
    assign w_ref_addr  = w_ref_full[AW-1:0];

    // A column that starts mid-page splits: low bits go to the first page
    // shifted down, the remaining high bits to the top of the next page.
    assign w_sh_hi = 4'd8 - {1'b0, r_shift};

    always_comb begin
        if (!r_op_col) begin
            w_mask = 8'd1 << r_shift;
            w_bits = {8{r_pv}};
        end else if (i_cmd.hi) begin
            w_mask = 8'hFF >> w_sh_hi;
            w_bits = r_pat >> w_sh_hi;
        end else begin
            w_mask = 8'hFF << r_shift;
            w_bits = r_pat << r_shift;
        end
    end

    assign w_merged = (r_rdata & ~w_mask) | (w_bits & w_mask);

    assign w_we    = i_cmd.clr_wr || (i_cmd.wr && w_x_ok && w_page_ok);
    assign w_waddr = i_cmd.clr_wr ? r_clr_addr : w_rmw_addr;
    assign w_wdata = i_cmd.clr_wr ? 8'd0 : w_merged;
    assign w_re    = i_cmd.rd || i_cmd.ref_rd;
    assign w_raddr = i_cmd.ref_rd ? w_ref_addr : w_rmw_addr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= o_sts.sweep_last ? '0 : r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= CFG_OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_data;
        end
    end

    assign w_last_idx  = (r_ref_idx == IW'(HEADER_LEN + COLUMNS - 1));
    assign w_last_page = (r_ref_page == PW'(PAGES - 1));

    always_comb begin
        w_ref_data = 1'b0;
        case (r_ref_idx)
            IW'(IDX_PAGE_CMD): w_ref_byte = CMD_PAGE + 8'(r_ref_page);
            IW'(IDX_COL_LOW):  w_ref_byte = {4'h0, r_offset[3:0]};
            IW'(IDX_COL_HIGH): w_ref_byte = CMD_COL_HIGH | {4'h0, r_offset[7:4]};
            default: begin
                w_ref_byte = r_rdata;
                w_ref_data = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_page <= '0;
            r_ref_idx  <= '0;
        end else if (i_cmd.ref_load) begin
            if (w_last_idx) begin
                r_ref_idx  <= '0;
                r_ref_page <= w_last_page ? '0 : r_ref_page + PW'(1);
            end else begin
                r_ref_idx <= r_ref_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.ref_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ref_load) begin
            r_o_byte <= w_ref_byte;
            r_o_data <= w_ref_data;
            r_o_last <= w_last_idx && w_last_page;
        end
    end

    assign o_sts.need_hi    = r_op_col && (r_shift != 3'd0) && w_x_ok
                              && (w_page_next < 6'(PAGES));
    assign o_sts.sweep_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.out_free   = !r_o_valid || !i_stall;

    assign o_valid         = r_o_valid;
    assign o_out_byte      = r_o_byte;
    assign o_is_data       = r_o_data;
    assign o_last_of_frame = r_o_last;

endmodule

[rtl/core/page_framebuffer_with_refresh_stream.sv]
// Channel      Direction  Handshake          Payload
// request      in         i_valid / o_stall  i_action, i_x_coord, i_y_coord, i_pattern,
//                                            i_pixel_value
// result       out        o_valid / i_stall  o_out_byte, o_is_data, o_last_of_frame
// config       in         i_cfg_we           i_cfg_data (column offset)
//
// Draw point and draw column make one read-modify-write pass of the store per touched
// page; a refresh step reads the store, then waits as long as the output register is held;
// clear zeroes the whole store, one store entry per cycle.
// After reset a clearing pass over all COLUMNS*PAGES entries zeroes the store while o_stall is high.
// Reset is synchronous, active low. A held result stalls only refresh steps; draws go on.
`include "page_framebuffer_with_refresh_stream_defines.svh"

module page_framebuffer_with_refresh_stream
    import pgfb_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_x_coord,
    input  logic [7:0] i_y_coord,
    input  logic [7:0] i_pattern,
    input  logic       i_pixel_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_last_of_frame,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    // The controller sequences each request: it accepts only when idle, then
    // steps the datapath through store reads, writes, the clear sweep or the
    // refresh load. The datapath holds the store, the refresh position, the
    // column offset register and the output register.
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pgfb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd),
        .i_sts    (w_sts)
    );

    pgfb_dp #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_action        (i_action),
        .i_x_coord       (i_x_coord),
        .i_y_coord       (i_y_coord),
        .i_pattern       (i_pattern),
        .i_pixel_value   (i_pixel_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_is_data       (o_is_data),
        .o_last_of_frame (o_last_of_frame)
    );

    // Once a request is taken the block is busy for at least the next cycle.
    `PGFB_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // The clear sweep owns the store port and excludes every other command.
    `PGFB_ASSERT_IMP(a_sweep_exclusive, i_clk, i_rst_n, w_cmd.clr_wr,
                     !w_cmd.wr && !w_cmd.rd && !w_cmd.ref_rd && !w_cmd.load)
    // A refresh byte is loaded only when the output register can take it.
    `PGFB_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, w_cmd.ref_load, w_sts.out_free)
    // The end-of-frame mark only ever sits on a data byte.
    `PGFB_ASSERT_IMP(a_last_is_data, i_clk, i_rst_n, o_valid && o_last_of_frame, o_is_data)

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the page-mode frame buffer. Draw, clear and refresh
// requests go in on the request channel; refresh bytes come back on the result
// channel. A predictor inside the bench keeps its own copy of the frame store,
// the refresh position and the column offset. It works out each refresh byte
// when its request is accepted and checks the returned bytes in order.
module tb_top;
    import pgfb_pkg::*;

    localparam int STORE_ENTRIES = DEF_COLUMNS * DEF_PAGES;
    localparam int SCREEN_ROWS   = DEF_PAGES * 8;
    localparam int PAGE_STEPS    = HEADER_LEN + DEF_COLUMNS;
    // A clear walks the whole store one entry per cycle and returns nothing,
    // so an idle wait has to outlast one full sweep.
    localparam int DRAIN_CYCLES  = STORE_ENTRIES + 64;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int MAX_WAIT      = 18;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last_of_frame;
    } t_stream_byte;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic [1:0] i_action        = ACT_POINT;
    logic [7:0] i_x_coord       = 8'h00;
    logic [7:0] i_y_coord       = 8'h00;
    logic [7:0] i_pattern       = 8'h00;
    logic       i_pixel_value   = 1'b0;
    logic       i_stall         = 1'b0;
    logic       i_cfg_we        = 1'b0;
    logic [7:0] i_cfg_data      = 8'h00;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_is_data;
    logic       o_last_of_frame;

    // Predicted state of the block.
    logic [7:0] frame_store [0:STORE_ENTRIES-1];
    logic [2:0] stream_page;
    logic [7:0] stream_index;
    logic [7:0] col_offset;

    // Refresh bytes predicted but not yet returned, oldest first.
    t_stream_byte stream_due [$];

    int  errors        = 0;
    int  frames_done   = 0;
    int  requests_sent = 0;
    int  cycle_count   = 0;
    int  stall_left    = 0;
    // When set, the matching side runs flat out for a stretch of requests.
    bit  sender_no_gaps    = 1'b0;
    bit  receiver_no_stall = 1'b0;

    page_framebuffer_with_refresh_stream #(
        .COLUMNS(DEF_COLUMNS),
        .PAGES  (DEF_PAGES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_pattern      (i_pattern),
        .i_pixel_value  (i_pixel_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_is_data      (o_is_data),
        .o_last_of_frame(o_last_of_frame),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Pixels off the screen leave the store alone.
    task automatic set_store_pixel(input int x, input int y, input logic on);
        int addr;
        if (x < DEF_COLUMNS && y < SCREEN_ROWS) begin
            addr = (y / 8) * DEF_COLUMNS + x;
            frame_store[addr][y % 8] = on;
        end
    endtask

    // Applies one accepted request to the predicted state. A refresh step
    // also queues the byte that the block must return for it.
    task automatic update_frame_and_stream(input t_action act, input logic [7:0] x,
                                           input logic [7:0] y, input logic [7:0] pat,
                                           input logic pv);
        t_stream_byte next_byte;
        int addr;
        case (act)
            ACT_POINT: begin
                set_store_pixel(x, y, pv);
            end
            ACT_COLUMN: begin
                // An inverted column writes the complement of every pattern bit.
                for (int m = 0; m < 8; m++) begin
                    set_store_pixel(x, y + m, pv ? pat[m] : !pat[m]);
                end
            end
            ACT_CLEAR: begin
                // The refresh position is kept; only the pixels go.
                foreach (frame_store[i]) begin
                    frame_store[i] = 8'h00;
                end
            end
            default: begin
                next_byte.is_data       = 1'b0;
                next_byte.last_of_frame = 1'b0;
                case (stream_index)
                    IDX_PAGE_CMD: next_byte.out_byte = CMD_PAGE + {5'b0, stream_page};
                    IDX_COL_LOW:  next_byte.out_byte = col_offset & 8'h0F;
                    IDX_COL_HIGH: next_byte.out_byte = CMD_COL_HIGH | (col_offset >> 4);
                    default: begin
                        // Data bytes show the store as it is now, so draws made
                        // partway through a frame appear in it.
                        addr = stream_page * DEF_COLUMNS + stream_index - HEADER_LEN;
                        next_byte.out_byte = frame_store[addr];
                        next_byte.is_data  = 1'b1;
                    end
                endcase
                if (stream_index == PAGE_STEPS - 1) begin
                    stream_index = 8'd0;
                    if (stream_page == DEF_PAGES - 1) begin
                        // The frame ends here and the next step starts over at page 0.
                        stream_page = 3'd0;
                        next_byte.last_of_frame = 1'b1;
                        frames_done++;
                    end else begin
                        stream_page = stream_page + 3'd1;
                    end
                end else begin
                    stream_index = stream_index + 8'd1;
                end
                stream_due.push_back(next_byte);
            end
        endcase
    endtask

    // Offers one request after a random gap and holds it until the block takes it.
    // Valid stays high across back-to-back requests, so it is only lowered for a gap.
    task automatic send_request(input t_action act, input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] pat, input logic pv);
        int gap;
        requests_sent++;
        if (requests_sent % 40 == 0) begin
            sender_no_gaps    = ($urandom_range(0, 3) == 0);
            receiver_no_stall = ($urandom_range(0, 3) == 0);
        end
        gap = sender_no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_x_coord     <= x;
        i_y_coord     <= y;
        i_pattern     <= pat;
        i_pixel_value <= pv;
        do @(posedge i_clk); while (o_stall);
        update_frame_and_stream(act, x, y, pat, pv);
    endtask

    // Mostly on-screen coordinates, with now and then the full 8-bit range so
    // that clipping and off-screen requests keep turning up.
    task automatic send_random_request(input int refresh_pct);
        int roll;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] pat;
        logic pv;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0) x = $urandom_range(0, 255);
        else x = $urandom_range(0, DEF_COLUMNS - 1);
        if ($urandom_range(0, 7) == 0) y = $urandom_range(0, 255);
        else y = $urandom_range(0, SCREEN_ROWS - 1);
        pat = $urandom_range(0, 255);
        pv  = $urandom_range(0, 1);
        if (roll < refresh_pct) begin
            send_request(ACT_REFRESH, x, y, pat, pv);
        end else if (roll == 99) begin
            send_request(ACT_CLEAR, x, y, pat, pv);
        end else if (roll < refresh_pct + (99 - refresh_pct) / 3) begin
            send_request(ACT_POINT, x, y, pat, pv);
        end else begin
            send_request(ACT_COLUMN, x, y, pat, pv);
        end
    endtask

    // Stops sending, waits for every predicted byte, then lets a full clear
    // sweep's worth of cycles pass so that no request is still at work.
    task automatic wait_for_drain;
        i_valid <= 1'b0;
        while (stream_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The offset register is only written while the block is idle.
    task automatic write_column_offset(input logic [7:0] value);
        wait_for_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        col_offset = value;
    endtask

    // Right after reset the stream opens page 0 with the reset column offset,
    // and the first data bytes are zero since reset clears the store.
    task automatic test_stream_after_reset;
        repeat (5) send_request(ACT_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    // Corners of the screen, a set followed by a clear of the same pixel,
    // and points past the right edge, below the bottom and at the far corner.
    task automatic test_draw_point_edges;
        send_request(ACT_POINT, 8'd0,   8'd0,   8'h00, 1'b1);
        send_request(ACT_POINT, 8'd127, 8'd63,  8'hFF, 1'b1);
        send_request(ACT_POINT, 8'd64,  8'd31,  8'h00, 1'b1);
        send_request(ACT_POINT, 8'd64,  8'd31,  8'h00, 1'b0);
        send_request(ACT_POINT, 8'd128, 8'd5,   8'h00, 1'b1);
        send_request(ACT_POINT, 8'd3,   8'd64,  8'h00, 1'b1);
        send_request(ACT_POINT, 8'd255, 8'd255, 8'hFF, 1'b1);
    endtask

    // Columns clipped at the bottom, spanning two pages, inverted, at the last
    // column, past the right edge and starting wholly below the screen.
    task automatic test_draw_column_edges;
        send_request(ACT_COLUMN, 8'd5,   8'd60,  8'hA5, 1'b1);
        send_request(ACT_COLUMN, 8'd6,   8'd3,   8'h0F, 1'b0);
        send_request(ACT_COLUMN, 8'd127, 8'd0,   8'h3C, 1'b1);
        send_request(ACT_COLUMN, 8'd128, 8'd8,   8'hFF, 1'b1);
        send_request(ACT_COLUMN, 8'd2,   8'd255, 8'hFF, 1'b1);
        send_request(ACT_COLUMN, 8'd4,   8'd56,  8'h00, 1'b0);
    endtask

    // A clear wipes the pixels but the stream carries on from where it was.
    task automatic test_clear_store;
        send_request(ACT_COLUMN, 8'd1, 8'd0, 8'hFF, 1'b1);
        send_request(ACT_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        repeat (3) send_request(ACT_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    // Walks the stream through the end of a frame and into the next one, with
    // a few draws and clears landing while the frame is being sent.
    task automatic test_full_frame_wrap;
        int frames_at_start;
        frames_at_start = frames_done;
        while (frames_done == frames_at_start) send_random_request(92);
        repeat (4) send_request(ACT_REFRESH, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    // Enough refresh steps per call to pass at least one set of page commands.
    task automatic test_random_mix(input int count);
        repeat (count) send_random_request(80);
    endtask

    // Result side: stalls a random number of cycles before each result, checks
    // every accepted byte against the oldest prediction.
    always @(posedge i_clk) begin
        t_stream_byte want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (stream_due.size() == 0) begin
                    $display("%0t: unexpected result, out_byte %02h is_data %0b last %0b",
                             $time, o_out_byte, o_is_data, o_last_of_frame);
                    errors++;
                end else begin
                    want = stream_due.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.out_byte, o_out_byte);
                        errors++;
                    end
                    if (o_is_data !== want.is_data) begin
                        $display("%0t: is_data expected %0b actual %0b",
                                 $time, want.is_data, o_is_data);
                        errors++;
                    end
                    if (o_last_of_frame !== want.last_of_frame) begin
                        $display("%0t: last_of_frame expected %0b actual %0b",
                                 $time, want.last_of_frame, o_last_of_frame);
                        errors++;
                    end
                end
                stall_left = receiver_no_stall ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, stream_due.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        // The predictor starts from the reset state: empty store, stream at the
        // page 0 command and the reset column offset.
        foreach (frame_store[i]) begin
            frame_store[i] = 8'h00;
        end
        stream_page  = 3'd0;
        stream_index = 8'd0;
        col_offset   = CFG_OFFSET_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block spends its post-reset clearing pass with o_stall high, and
        // send_request simply waits that out.
        test_stream_after_reset();
        test_draw_point_edges();
        test_draw_column_edges();
        test_clear_store();

        // Each offset change comes after a full drain, which also gives the
        // sender a pause until every outstanding result is back.
        write_column_offset(8'd0);
        test_random_mix(200);
        write_column_offset(8'd131);
        test_random_mix(200);
        // All eight offset bits go into the commands, even above the panel range.
        write_column_offset(8'd255);
        test_random_mix(200);
        write_column_offset($urandom_range(0, 255));
        test_random_mix(200);
        write_column_offset($urandom_range(0, 255));
        test_full_frame_wrap();

        wait_for_drain();
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[page_framebuffer_with_refresh_stream.f]
+incdir+rtl/core
rtl/core/pgfb_pkg.sv
rtl/core/pgfb_ctrl.sv
rtl/core/pgfb_dp.sv
rtl/core/page_framebuffer_with_refresh_stream.sv
sim/tb_top.sv
